FILE: sv/tlb_translate_probe_write_macros.svh
// Assertion macros used by the TLB top-level RTL file
`ifndef TLB_TRANSLATE_PROBE_WRITE_MACROS_SVH
`define TLB_TRANSLATE_PROBE_WRITE_MACROS_SVH

// checked only outside reset
`define TLB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define TLB_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/tlb_pkg.sv
// Types, constants and request codes of the joint TLB
`timescale 1ns / 1ps
package tlb_pkg;

  localparam int NUM_ENTRIES = 32;
  localparam int IDX_W       = $clog2(NUM_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

  localparam logic [31:0] VPN2_BITS    = 32'hFFFF_E000;
  localparam logic [31:0] PAGE_LOW     = 32'h0000_1FFF;
  localparam logic [31:0] PFN_FIELD    = 32'h03FF_FFC0;
  localparam logic [31:0] KSEG_OFFSET  = 32'h1FFF_FFFF;
  localparam logic [31:0] KSEG0_BASE   = 32'h8000_0000;
  localparam logic [31:0] KSEG_END     = 32'hC000_0000;
  localparam logic [31:0] ENTRYHI_BITS = 32'hFFFF_E0FF;
  localparam logic [31:0] ASID_BITS    = 32'h0000_00FF;
  localparam logic [31:0] MASK_BITS    = 32'h01FF_E000;

  localparam logic [2:0] REQ_TRANSLATE = 3'd0;
  localparam logic [2:0] REQ_WRITE     = 3'd1;
  localparam logic [2:0] REQ_READ      = 3'd2;
  localparam logic [2:0] REQ_PROBE     = 3'd3;
  localparam logic [2:0] REQ_SET_HI    = 3'd4;
  localparam logic [2:0] REQ_FAULT     = 3'd5;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] virt_addr;
    logic [4:0]  entry_index;
    logic [31:0] new_lo_even;
    logic [31:0] new_lo_odd;
    logic [31:0] new_hi;
    logic [31:0] new_mask;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic        read_only;
    logic [31:0] phys_addr;
    logic        probe_miss;
    logic [4:0]  probe_index;
    logic [31:0] rd_lo_even;
    logic [31:0] rd_lo_odd;
    logic [31:0] rd_hi;
    logic [31:0] rd_mask;
    logic [31:0] cur_entry_hi;
  } rsp_t;

  typedef struct packed {
    logic [31:0] hi;
    logic [31:0] lo_even;
    logic [31:0] lo_odd;
    logic [31:0] mask;
  } entry_t;

  typedef struct packed {
    logic        tag_hit;
    logic        half_valid;
    logic        read_only;
    logic [31:0] phys_addr;
  } match_t;

endpackage

FILE: sv/tlb_entry_ram.sv
// Entry memory: one write port, one registered read port, valid bit per entry
`timescale 1ns / 1ps
module tlb_entry_ram (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [tlb_pkg::IDX_W-1:0]  wr_addr,
  input  tlb_pkg::entry_t            wr_data,
  input  logic                       rd_en,
  input  logic [tlb_pkg::IDX_W-1:0]  rd_addr,
  output tlb_pkg::entry_t            rd_data
);

  tlb_pkg::entry_t                   mem [tlb_pkg::NUM_ENTRIES];
  logic [tlb_pkg::NUM_ENTRIES-1:0]   valid;
  tlb_pkg::entry_t                   rd_q;
  logic                              rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= valid[rd_addr];
      end
    end
  end

  // entries not written since reset read as zero
  assign rd_data = rd_vld ? rd_q : '0;

endmodule

FILE: sv/tlb_match_unit.sv
// Shared compare unit: tag match and address formation for one entry
`timescale 1ns / 1ps
module tlb_match_unit (
  input  tlb_pkg::entry_t  ent,
  input  logic [31:0]      key,
  input  logic [7:0]       asid,
  output tlb_pkg::match_t  res
);

  logic [31:0] cmp;
  logic        vpn_eq;
  logic        asid_eq;
  logic [31:0] odd_bit;
  logic [31:0] offs;
  logic [31:0] lo;
  logic [31:0] pfn;

  always_comb begin
    cmp     = ~ent.mask & tlb_pkg::VPN2_BITS;
    vpn_eq  = (ent.hi & cmp) == (key & cmp);
    asid_eq = ent.hi[7:0] == asid;
    odd_bit = ((ent.mask | tlb_pkg::PAGE_LOW) + 32'd1) >> 1;
    offs    = odd_bit - 32'd1;
    lo      = ((key & odd_bit) != '0) ? ent.lo_odd : ent.lo_even;
    pfn     = (lo & tlb_pkg::PFN_FIELD) << 6;
    res.tag_hit    = vpn_eq && (ent.lo_even[0] || asid_eq);
    res.half_valid = lo[1];
    res.read_only  = ~lo[2];
    res.phys_addr  = (pfn & ~offs) | (key & offs);
  end

endmodule

FILE: sv/tlb_translate_probe_write.sv
// Joint TLB top level: request sequencer, entry scan and result register
//
//   channel | signals                     | moves
//   --------+-----------------------------+------------------------
//   req     | req_valid, req_ready, req   | one request item
//   rsp     | rsp_valid, rsp_ready, rsp   | one result item
//
// Translate (mapped) and probe scan the entries one per cycle through the
// shared compare unit fed by the entry memory read port. Read passes through a
// read-wait state before the finish state; the remaining requests go straight to it.
// Reset clears all entries at once through per-entry valid bits.
// A finished result waits in the output register; the next item may be
// accepted and worked on meanwhile, holding only its own result stage.
`timescale 1ns / 1ps
`include "tlb_translate_probe_write_macros.svh"
module tlb_translate_probe_write (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  tlb_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output tlb_pkg::rsp_t  rsp
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_RDWT = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]                state;
  logic [tlb_pkg::IDX_W-1:0] cnt;
  logic                      issuing;
  logic                      pipe_vld;
  logic [tlb_pkg::IDX_W-1:0] pipe_idx;
  logic                      is_probe;
  logic [31:0]               key;
  logic [31:0]               entry_hi;
  tlb_pkg::rsp_t             res;

  logic                      accept;
  logic                      in_range;
  logic                      wr_en;
  logic                      rd_en;
  logic [tlb_pkg::IDX_W-1:0] rd_addr;
  tlb_pkg::entry_t           wr_data;
  tlb_pkg::entry_t           rd_data;
  tlb_pkg::match_t           m;
  logic                      scan_hit;
  logic                      out_free;

  assign req_ready = state == ST_IDLE;
  assign accept    = req_valid && req_ready;
  assign in_range  = 7'(req.entry_index) < 7'(tlb_pkg::NUM_ENTRIES);
  assign wr_en     = accept && req.req_type == tlb_pkg::REQ_WRITE && in_range;
  assign out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    wr_data.hi      = req.new_hi;
    wr_data.lo_even = {req.new_lo_even[31:1], req.new_lo_even[0] & req.new_lo_odd[0]};
    wr_data.lo_odd  = {req.new_lo_odd[31:1], req.new_lo_even[0] & req.new_lo_odd[0]};
    wr_data.mask    = req.new_mask & tlb_pkg::MASK_BITS;
  end

  always_comb begin
    if (state == ST_IDLE) begin
      rd_en   = accept && req.req_type == tlb_pkg::REQ_READ && in_range;
      rd_addr = tlb_pkg::IDX_W'(req.entry_index);
    end else begin
      rd_en   = state == ST_SCAN && issuing;
      rd_addr = cnt;
    end
  end

  tlb_entry_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (tlb_pkg::IDX_W'(req.entry_index)),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tlb_match_unit u_match (
    .ent  (rd_data),
    .key  (key),
    .asid (entry_hi[7:0]),
    .res  (m)
  );

  assign scan_hit = m.tag_hit && (is_probe || m.half_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      entry_hi  <= '0;
      rsp_valid <= 1'b0;
      issuing   <= 1'b0;
      pipe_vld  <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            res      <= '0;
            cnt      <= '0;
            pipe_vld <= 1'b0;
            is_probe <= req.req_type == tlb_pkg::REQ_PROBE;
            key      <= req.virt_addr;
            state    <= ST_FIN;
            case (req.req_type)
              tlb_pkg::REQ_TRANSLATE: begin
                if (req.virt_addr >= tlb_pkg::KSEG0_BASE &&
                    req.virt_addr < tlb_pkg::KSEG_END) begin
                  res.hit       <= 1'b1;
                  res.phys_addr <= req.virt_addr & tlb_pkg::KSEG_OFFSET;
                end else begin
                  issuing <= 1'b1;
                  state   <= ST_SCAN;
                end
              end
              tlb_pkg::REQ_READ: begin
                if (in_range) begin
                  state <= ST_RDWT;
                end
              end
              tlb_pkg::REQ_PROBE: begin
                key     <= entry_hi;
                issuing <= 1'b1;
                state   <= ST_SCAN;
              end
              tlb_pkg::REQ_SET_HI: begin
                entry_hi <= req.new_hi & tlb_pkg::ENTRYHI_BITS;
              end
              tlb_pkg::REQ_FAULT: begin
                entry_hi <= (req.virt_addr & tlb_pkg::VPN2_BITS) |
                            (entry_hi & tlb_pkg::ASID_BITS);
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (issuing) begin
            if (cnt == tlb_pkg::LAST_IDX) begin
              issuing <= 1'b0;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
          pipe_vld <= issuing;
          pipe_idx <= cnt;
          if (pipe_vld) begin
            if (scan_hit) begin
              issuing  <= 1'b0;
              pipe_vld <= 1'b0;
              state    <= ST_FIN;
              if (is_probe) begin
                res.probe_index <= 5'(pipe_idx);
              end else begin
                res.hit       <= 1'b1;
                res.read_only <= m.read_only;
                res.phys_addr <= m.phys_addr;
              end
            end else if (pipe_idx == tlb_pkg::LAST_IDX) begin
              pipe_vld <= 1'b0;
              state    <= ST_FIN;
              if (is_probe) begin
                res.probe_miss <= 1'b1;
              end
            end
          end
        end
        ST_RDWT: begin
          res.rd_lo_even <= rd_data.lo_even;
          res.rd_lo_odd  <= rd_data.lo_odd;
          res.rd_hi      <= rd_data.hi;
          res.rd_mask    <= rd_data.mask;
          state          <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      rsp              <= res;
      rsp.cur_entry_hi <= entry_hi;
    end
  end

  `TLB_ASSERT_RST(a_reset_idle,
                  rst |=> (state == ST_IDLE && !rsp_valid),
                  "reset not idle")
  `TLB_ASSERT(a_probe_scans,
              (accept && req.req_type == tlb_pkg::REQ_PROBE) |=> state == ST_SCAN,
              "probe did not start scan")
  `TLB_ASSERT(a_fin_delivers,
              (state == ST_FIN && out_free) |=> (state == ST_IDLE && rsp_valid),
              "result not delivered")
  `TLB_ASSERT(a_no_hit_and_miss,
              rsp_valid |-> !(rsp.hit && rsp.probe_miss),
              "hit and probe miss together")
  `TLB_ASSERT(a_issue_only_scan,
              issuing |-> state == ST_SCAN,
              "entry read outside scan")

endmodule

FILE: tb/tlb_translate_probe_write_tb.sv
// Testbench for the joint TLB: directed and random requests checked against a shadow TLB
`timescale 1ns / 1ps
module tlb_translate_probe_write_tb;

  localparam logic [2:0] REQ_RSVD6 = 3'd6;
  localparam logic [2:0] REQ_RSVD7 = 3'd7;
  localparam int RANDOM_ITEMS = 550;
  localparam int IDLE_LIMIT   = 4000;
  localparam int TAIL_CYCLES  = 60;

  typedef struct packed {
    logic          drain;
    tlb_pkg::req_t item;
  } pending_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_ready;
  tlb_pkg::req_t req = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  tlb_pkg::rsp_t rsp;

  tlb_translate_probe_write DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow copy of the TLB
  logic [31:0] sh_tag     [tlb_pkg::NUM_ENTRIES];
  logic [31:0] sh_lo_even [tlb_pkg::NUM_ENTRIES];
  logic [31:0] sh_lo_odd  [tlb_pkg::NUM_ENTRIES];
  logic [31:0] sh_mask    [tlb_pkg::NUM_ENTRIES];
  logic [31:0] sh_entry_hi;

  pending_t      request_q[$];
  tlb_pkg::rsp_t predicted_q[$];
  logic [2:0]    predicted_kind_q[$];

  int   errors = 0;
  int   idle_cycles = 0;
  int   req_gap = 0;
  int   rsp_stall = 0;
  bit   calm = 1'b0;
  logic req_took = 1'b0;
  int   n_req [8];
  int   n_xlate_hit = 0;
  int   n_probe_hit = 0;

  function automatic bit entry_matches(int i, logic [31:0] va, logic [7:0] asid);
    logic [31:0] cmp;
    cmp = ~sh_mask[i] & tlb_pkg::VPN2_BITS;
    return ((sh_tag[i] & cmp) == (va & cmp)) &&
           (sh_lo_even[i][0] || sh_tag[i][7:0] == asid);
  endfunction

  function automatic tlb_pkg::rsp_t tlb_predict(tlb_pkg::req_t r);
    tlb_pkg::rsp_t o;
    logic [7:0]    asid;
    logic [31:0]   odd_bit, lo, offs;
    logic          g;
    bit            found;
    int            i;
    o = '0;
    asid = sh_entry_hi[7:0];
    found = 1'b0;
    case (r.req_type)
      tlb_pkg::REQ_TRANSLATE: begin
        if (r.virt_addr >= tlb_pkg::KSEG0_BASE && r.virt_addr < tlb_pkg::KSEG_END) begin
          o.hit = 1'b1;
          o.phys_addr = r.virt_addr & tlb_pkg::KSEG_OFFSET;
        end else begin
          for (i = 0; i < tlb_pkg::NUM_ENTRIES; i++) begin
            if (!found && entry_matches(i, r.virt_addr, asid)) begin
              odd_bit = ((sh_mask[i] | tlb_pkg::PAGE_LOW) + 32'd1) >> 1;
              lo = ((r.virt_addr & odd_bit) != 0) ? sh_lo_odd[i] : sh_lo_even[i];
              // invalid half: keep searching
              if (lo[1]) begin
                found = 1'b1;
                offs = odd_bit - 32'd1;
                o.hit = 1'b1;
                o.read_only = !lo[2];
                o.phys_addr = (((lo & tlb_pkg::PFN_FIELD) << 6) & ~offs) |
                              (r.virt_addr & offs);
              end
            end
          end
        end
      end
      tlb_pkg::REQ_WRITE: begin
        if (r.entry_index < tlb_pkg::NUM_ENTRIES) begin
          g = r.new_lo_even[0] & r.new_lo_odd[0];
          sh_tag[r.entry_index]     = r.new_hi;
          sh_lo_even[r.entry_index] = {r.new_lo_even[31:1], g};
          sh_lo_odd[r.entry_index]  = {r.new_lo_odd[31:1], g};
          sh_mask[r.entry_index]    = r.new_mask & tlb_pkg::MASK_BITS;
        end
      end
      tlb_pkg::REQ_READ: begin
        if (r.entry_index < tlb_pkg::NUM_ENTRIES) begin
          o.rd_lo_even = sh_lo_even[r.entry_index];
          o.rd_lo_odd  = sh_lo_odd[r.entry_index];
          o.rd_hi      = sh_tag[r.entry_index];
          o.rd_mask    = sh_mask[r.entry_index];
        end
      end
      tlb_pkg::REQ_PROBE: begin
        o.probe_miss = 1'b1;
        for (i = 0; i < tlb_pkg::NUM_ENTRIES; i++) begin
          if (!found && entry_matches(i, sh_entry_hi, asid)) begin
            found = 1'b1;
            o.probe_miss = 1'b0;
            o.probe_index = 5'(i);
          end
        end
      end
      tlb_pkg::REQ_SET_HI: sh_entry_hi = r.new_hi & tlb_pkg::ENTRYHI_BITS;
      tlb_pkg::REQ_FAULT:  sh_entry_hi = (r.virt_addr & tlb_pkg::VPN2_BITS) |
                                         (sh_entry_hi & tlb_pkg::ASID_BITS);
      default: ;
    endcase
    o.cur_entry_hi = sh_entry_hi;
    return o;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      errors++;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 49) == 0) calm = !calm;
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic tlb_pkg::req_t mk(logic [2:0] kind, logic [31:0] va, logic [4:0] idx,
                                       logic [31:0] lo0, logic [31:0] lo1, logic [31:0] hi,
                                       logic [31:0] msk);
    tlb_pkg::req_t r;
    r.req_type = kind;
    r.virt_addr = va;
    r.entry_index = idx;
    r.new_lo_even = lo0;
    r.new_lo_odd = lo1;
    r.new_hi = hi;
    r.new_mask = msk;
    return r;
  endfunction

  function automatic void push_item(tlb_pkg::req_t r, logic drain);
    pending_t p;
    p.drain = drain;
    p.item = r;
    request_q.push_back(p);
  endfunction

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_took) begin
      if (req_gap > 0) begin
        req_gap--;
        req_valid <= 1'b0;
      end else if (request_q.size() == 0 ||
                   (request_q[0].drain && predicted_q.size() != 0)) begin
        req_valid <= 1'b0;
      end else begin
        req <= request_q[0].item;
        request_q.pop_front();
        req_valid <= 1'b1;
        req_gap = pick_gap();
      end
    end
  end

  // result backpressure
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (rsp_stall > 0) begin
      rsp_stall--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      rsp_ready <= (rsp_stall == 0);
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    tlb_pkg::rsp_t want;
    logic [2:0]    kind;
    if (rst) begin
      req_took <= 1'b0;
      idle_cycles <= 0;
    end else begin
      req_took <= req_valid && req_ready;
      if (req_valid && req_ready) begin
        predicted_q.push_back(tlb_predict(req));
        predicted_kind_q.push_back(req.req_type);
      end
      if (rsp_valid && rsp_ready) begin
        if (predicted_q.size() == 0) begin
          $error("result item with no request outstanding");
          errors++;
        end else begin
          want = predicted_q.pop_front();
          kind = predicted_kind_q.pop_front();
          n_req[kind]++;
          if (kind == tlb_pkg::REQ_TRANSLATE && want.hit) n_xlate_hit++;
          if (kind == tlb_pkg::REQ_PROBE && !want.probe_miss) n_probe_hit++;
          check_field("hit", want.hit, rsp.hit);
          check_field("read_only", want.read_only, rsp.read_only);
          check_field("phys_addr", want.phys_addr, rsp.phys_addr);
          check_field("probe_miss", want.probe_miss, rsp.probe_miss);
          check_field("probe_index", want.probe_index, rsp.probe_index);
          check_field("rd_lo_even", want.rd_lo_even, rsp.rd_lo_even);
          check_field("rd_lo_odd", want.rd_lo_odd, rsp.rd_lo_odd);
          check_field("rd_hi", want.rd_hi, rsp.rd_hi);
          check_field("rd_mask", want.rd_mask, rsp.rd_mask);
          check_field("cur_entry_hi", want.cur_entry_hi, rsp.cur_entry_hi);
        end
      end
      idle_cycles <= ((req_valid && req_ready) || (rsp_valid && rsp_ready)) ?
                     0 : idle_cycles + 1;
    end
  end

  initial begin : stimulus
    tlb_pkg::req_t r;
    logic [31:0]   vpn_pool [8];
    logic [7:0]    asid_pool [4];
    logic [31:0]   v;
    int            n, k, sel;
    bit            timed_out;
    timed_out = 1'b0;
    for (n = 0; n < tlb_pkg::NUM_ENTRIES; n++) begin
      sh_tag[n] = '0;
      sh_lo_even[n] = '0;
      sh_lo_odd[n] = '0;
      sh_mask[n] = '0;
    end
    sh_entry_hi = '0;
    for (n = 0; n < 8; n++) n_req[n] = 0;
    for (n = 0; n < 8; n++) begin
      v = $urandom & tlb_pkg::VPN2_BITS;
      if (v[31] && !v[30]) v[30] = 1'b1;  // keep mapped
      vpn_pool[n] = v;
    end
    asid_pool[0] = 8'h00;
    asid_pool[1] = 8'h12;
    asid_pool[2] = 8'hFF;
    asid_pool[3] = 8'($urandom);

    // directed
    push_item(mk(tlb_pkg::REQ_READ, 0, 0, 0, 0, 0, 0), 1'b0);
    push_item(mk(tlb_pkg::REQ_TRANSLATE, 32'h0000_0000, 0, 0, 0, 0, 0), 1'b0);
    push_item(mk(tlb_pkg::REQ_TRANSLATE, 32'h8000_0000, 0, 0, 0, 0, 0), 1'b0);
    push_item(mk(tlb_pkg::REQ_TRANSLATE, 32'hBFFF_FFFF, 0, 0, 0, 0, 0), 1'b0);
    push_item(mk(tlb_pkg::REQ_TRANSLATE, 32'h7FFF_FFFF, 0, 0, 0, 0, 0), 1'b0);
    push_item(mk(tlb_pkg::REQ_TRANSLATE, 32'hC000_0000, 0, 0, 0, 0, 0), 1'b0);
    push_item(mk(tlb_pkg::REQ_SET_HI, 0, 0, 0, 0, 32'hFFFF_FFFF, 0), 1'b0);
    push_item(mk(tlb_pkg::REQ_SET_HI, 0, 0, 0, 0, 32'h0040_2F12, 0), 1'b0);
    // entry 3 invalid on both halves, entry 7 valid with the same tag
    push_item(mk(tlb_pkg::REQ_WRITE, 0, 3, 32'h0000_0044, 32'h0000_0044,
                 32'h0040_2012, 0), 1'b0);
    push_item(mk(tlb_pkg::REQ_WRITE, 0, 7, 32'h048D_1406, 32'h0000_0043,
                 32'h0040_2012, 0), 1'b0);
    push_item(mk(tlb_pkg::REQ_TRANSLATE, 32'h0040_2ABC, 0, 0, 0, 0, 0), 1'b0);
    push_item(mk(tlb_pkg::REQ_TRANSLATE, 32'h0040_3ABC, 0, 0, 0, 0, 0), 1'b0);
    push_item(mk(tlb_pkg::REQ_PROBE, 0, 0, 0, 0, 0, 0), 1'b1);
    push_item(mk(tlb_pkg::REQ_READ, 0, 7, 0, 0, 0, 0), 1'b0);
    push_item(mk(tlb_pkg::REQ_WRITE, 0, 31, '1, '1, '1, '1), 1'b0);
    push_item(mk(tlb_pkg::REQ_READ, 0, 31, 0, 0, 0, 0), 1'b0);
    push_item(mk(tlb_pkg::REQ_SET_HI, 0, 0, 0, 0, 32'h0000_0055, 0), 1'b0);
    push_item(mk(tlb_pkg::REQ_TRANSLATE, 32'hFE12_3456, 0, 0, 0, 0, 0), 1'b0);
    push_item(mk(tlb_pkg::REQ_TRANSLATE, 32'hFF12_3456, 0, 0, 0, 0, 0), 1'b0);
    push_item(mk(tlb_pkg::REQ_FAULT, 32'hFFFF_FFFF, 0, 0, 0, 0, 0), 1'b0);
    push_item(mk(tlb_pkg::REQ_PROBE, 0, 0, 0, 0, 0, 0), 1'b0);
    push_item(mk(tlb_pkg::REQ_SET_HI, 0, 0, 0, 0, 32'h1234_5677, 0), 1'b0);
    push_item(mk(tlb_pkg::REQ_PROBE, 0, 0, 0, 0, 0, 0), 1'b0);
    push_item(mk(REQ_RSVD6, '1, '1, '1, '1, '1, '1), 1'b0);
    push_item(mk(REQ_RSVD7, '1, '1, '1, '1, '1, '1), 1'b0);

    // random: tags and ASIDs from small pools so translates and probes hit
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      r = mk(tlb_pkg::REQ_TRANSLATE, $urandom, 5'($urandom), $urandom, $urandom,
             $urandom, $urandom);
      sel = $urandom_range(0, 99);
      k = $urandom_range(0, 9);
      if (sel < 35) begin
        if (k < 7) begin
          r.virt_addr = vpn_pool[$urandom_range(0, 7)] | ($urandom & tlb_pkg::PAGE_LOW);
          if ($urandom_range(0, 3) == 0) r.virt_addr ^= $urandom & 32'h0001_E000;
        end else if (k < 9) begin
          r.virt_addr = tlb_pkg::KSEG0_BASE | ($urandom & 32'h3FFF_FFFF);
        end
      end else if (sel < 55) begin
        r.req_type = tlb_pkg::REQ_WRITE;
        r.new_hi = vpn_pool[$urandom_range(0, 7)] | asid_pool[$urandom_range(0, 3)] |
                   ($urandom & 32'h0000_1F00);
        if ($urandom_range(0, 4) != 0) r.new_lo_even[1] = 1'b1;
        if ($urandom_range(0, 4) != 0) r.new_lo_odd[1] = 1'b1;
        if (k < 6) r.new_mask = '0;
        else if (k < 9) r.new_mask = 32'h01FF_E000 >> (2 * $urandom_range(0, 5));
      end else if (sel < 65) begin
        r.req_type = tlb_pkg::REQ_READ;
      end else if (sel < 77) begin
        r.req_type = tlb_pkg::REQ_PROBE;
      end else if (sel < 87) begin
        r.req_type = tlb_pkg::REQ_SET_HI;
        if (k < 8) r.new_hi = vpn_pool[$urandom_range(0, 7)] |
                              asid_pool[$urandom_range(0, 3)] | ($urandom & 32'h0000_1F00);
      end else if (sel < 95) begin
        r.req_type = tlb_pkg::REQ_FAULT;
        if (k < 7) r.virt_addr = vpn_pool[$urandom_range(0, 7)] |
                                 ($urandom & tlb_pkg::PAGE_LOW);
      end else begin
        r.req_type = sel[0] ? REQ_RSVD7 : REQ_RSVD6;
      end
      push_item(r, (n == 0) || ($urandom_range(0, 99) == 0));
    end

    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    fork
      begin
        wait (request_q.size() == 0 && !req_valid);
        wait (predicted_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
      end
      begin
        wait (idle_cycles >= IDLE_LIMIT);
        $error("no item moved for %0d cycles", IDLE_LIMIT);
        timed_out = 1'b1;
      end
    join_any
    disable fork;

    if (!timed_out) begin
      $display("Checked %0d translates (%0d hit), %0d writes, %0d reads, %0d probes (%0d hit)",
               n_req[tlb_pkg::REQ_TRANSLATE], n_xlate_hit, n_req[tlb_pkg::REQ_WRITE],
               n_req[tlb_pkg::REQ_READ], n_req[tlb_pkg::REQ_PROBE], n_probe_hit);
      $display("plus %0d EntryHi sets, %0d fault loads, %0d reserved codes; %0d errors",
               n_req[tlb_pkg::REQ_SET_HI], n_req[tlb_pkg::REQ_FAULT],
               n_req[REQ_RSVD6] + n_req[REQ_RSVD7], errors);
    end
    if (!timed_out && errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
